// ----- rtl/csp_pkg.sv -----
// Shared widths, codes, types and helpers for the color spill suppression pipeline.
package csp_pkg;

   // Field widths
   localparam int DataWidth     = 16;
   localparam int ScaleWidth    = 13;
   localparam int CfgIndexWidth = 3;
   localparam int CfgDataWidth  = 13;
   localparam int ChanWidth     = 2;

   // Internal arithmetic widths
   localparam int Ref2Width  = DataWidth + 1;
   localparam int ScaledWidth = ScaleWidth + 1 + Ref2Width;
   localparam int DiffWidth  = 32;
   localparam int MapWidth   = DataWidth + DiffWidth;
   localparam int MagWidth   = 45;
   localparam int ProdWidth  = ScaleWidth + MagWidth;
   localparam int RoundShift = 37;
   localparam int CorrWidth  = ProdWidth - RoundShift;
   localparam int SumWidth   = CorrWidth + 2;

   // Unit value in Q4.12
   localparam logic [ScaleWidth-1:0]       QOne      = ScaleWidth'(4096);
   localparam logic signed [DataWidth-1:0] FactorCap = DataWidth'(4096);
   localparam logic [ScaleWidth-1:0]       LimitScaleReset = ScaleWidth'(4096);

   // Channel codes
   localparam logic [ChanWidth-1:0] ChanRed   = 2'd0;
   localparam logic [ChanWidth-1:0] ChanGreen = 2'd1;
   localparam logic [ChanWidth-1:0] ChanBlue  = 2'd2;

   // Reference methods
   localparam logic MethodSimple  = 1'b0;
   localparam logic MethodAverage = 1'b1;

   // Register indexes
   typedef enum logic [CfgIndexWidth-1:0] {
      CfgSpillChannel,
      CfgSpillMethod,
      CfgLimitChannel,
      CfgLimitScale,
      CfgUnspillEnable,
      CfgGainRed,
      CfgGainGreen,
      CfgGainBlue
   } cfg_index_type;

   typedef struct packed {
      logic [ChanWidth-1:0]  spill_channel;
      logic                  spill_method;
      logic [ChanWidth-1:0]  limit_channel;
      logic [ScaleWidth-1:0] limit_scale;
      logic                  unspill_enable;
      logic [ScaleWidth-1:0] gain_red;
      logic [ScaleWidth-1:0] gain_green;
      logic [ScaleWidth-1:0] gain_blue;
   } cfg_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] red;
      logic signed [DataWidth-1:0] green;
      logic signed [DataWidth-1:0] blue;
      logic signed [DataWidth-1:0] alpha;
   } pixel_type;

   // Word leaving the difference stage
   typedef struct packed {
      pixel_type                   pix;
      logic [ChanWidth-1:0]        spill;
      logic signed [DataWidth-1:0] factor;
      logic signed [DiffWidth-1:0] diff;
   } diff_stage_type;

   // Word leaving the correction stage
   typedef struct packed {
      pixel_type            pix;
      logic [ChanWidth-1:0] spill;
      logic [CorrWidth-1:0] corr_red;
      logic [CorrWidth-1:0] corr_green;
      logic [CorrWidth-1:0] corr_blue;
   } corr_stage_type;

   // Code three selects blue
   function automatic logic [ChanWidth-1:0] chan_clamp(input logic [ChanWidth-1:0] code);
      chan_clamp = (code > ChanBlue) ? ChanBlue : code;
   endfunction

endpackage

// ----- rtl/csp_req_if.sv -----
// Pixel request channel: valid/ready with RGBA pixel and strength.
interface csp_req_if import csp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] in_red;
   logic signed [DataWidth-1:0] in_green;
   logic signed [DataWidth-1:0] in_blue;
   logic signed [DataWidth-1:0] in_alpha;
   logic signed [DataWidth-1:0] strength;

   modport source (output valid, output in_red, output in_green, output in_blue,
                   output in_alpha, output strength, input ready);
   modport sink   (input valid, input in_red, input in_green, input in_blue,
                   input in_alpha, input strength, output ready);
endinterface

// ----- rtl/csp_rsp_if.sv -----
// Pixel response channel: valid/ready with corrected RGBA pixel.
interface csp_rsp_if import csp_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [DataWidth-1:0] out_red;
   logic signed [DataWidth-1:0] out_green;
   logic signed [DataWidth-1:0] out_blue;
   logic signed [DataWidth-1:0] out_alpha;

   modport source (output valid, output out_red, output out_green, output out_blue,
                   output out_alpha, input ready);
   modport sink   (input valid, input out_red, input out_green, input out_blue,
                   input out_alpha, output ready);
endinterface

// ----- rtl/csp_diff.sv -----
// First stage: reference selection, scaled difference and strength cap.
module csp_diff import csp_pkg::*; (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  pixel_type                   in_pix,
   input  logic signed [DataWidth-1:0] in_strength,
   output logic                        out_valid,
   input  logic                        out_ready,
   output diff_stage_type              out_stage
);

   logic [ChanWidth-1:0]          sc;
   logic [ChanWidth-1:0]          lc;
   logic signed [DataWidth-1:0]   c_sc;
   logic signed [DataWidth-1:0]   c_lc;
   logic signed [Ref2Width-1:0]   other_sum;
   logic signed [Ref2Width-1:0]   ref2;
   logic signed [ScaledWidth-1:0] scaled;
   logic signed [DiffWidth-1:0]   diff;
   logic signed [DataWidth-1:0]   factor;
   logic                          valid_ff;
   logic                          valid_in;
   diff_stage_type                stage_ff;
   diff_stage_type                stage_in;

   // Pick spill value and the sum of the other two channels
   always_comb begin
      sc = chan_clamp(cfg.spill_channel);
      unique case (sc)
         ChanRed: begin
            c_sc      = in_pix.red;
            other_sum = Ref2Width'(in_pix.green) + Ref2Width'(in_pix.blue);
         end
         ChanGreen: begin
            c_sc      = in_pix.green;
            other_sum = Ref2Width'(in_pix.red) + Ref2Width'(in_pix.blue);
         end
         default: begin
            c_sc      = in_pix.blue;
            other_sum = Ref2Width'(in_pix.red) + Ref2Width'(in_pix.green);
         end
      endcase
   end

   // Pick the limit channel for the simple method
   always_comb begin
      lc = chan_clamp(cfg.limit_channel);
      unique case (lc)
         ChanRed:   c_lc = in_pix.red;
         ChanGreen: c_lc = in_pix.green;
         default:   c_lc = in_pix.blue;
      endcase
   end

   // Doubled reference, scaled difference and capped strength
   always_comb begin
      ref2   = (cfg.spill_method == MethodAverage) ? other_sum : {c_lc, 1'b0};
      scaled = $signed({1'b0, cfg.limit_scale}) * ref2;
      diff   = {{(DiffWidth-DataWidth-ScaleWidth){c_sc[DataWidth-1]}}, c_sc,
                {ScaleWidth{1'b0}}} - DiffWidth'(scaled);
      factor = (in_strength > FactorCap) ? FactorCap : in_strength;
   end

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      stage_in = stage_ff;
      if (in_ready && in_valid) begin
         stage_in.pix    = in_pix;
         stage_in.spill  = sc;
         stage_in.factor = factor;
         stage_in.diff   = diff;
      end
   end

   // Hold the word until the next stage takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      stage_ff <= stage_in;
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ----- rtl/csp_corr.sv -----
// Second and third stages: spill map product, then per-channel rounded corrections.
module csp_corr import csp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  cfg_type        cfg,
   input  logic           in_valid,
   output logic           in_ready,
   input  diff_stage_type in_stage,
   output logic           out_valid,
   input  logic           out_ready,
   output corr_stage_type out_stage
);

   typedef struct packed {
      pixel_type                  pix;
      logic [ChanWidth-1:0]       spill;
      logic signed [MapWidth-1:0] map;
   } map_stage_type;

   logic                 map_valid_ff;
   logic                 map_valid_in;
   logic                 map_ready;
   map_stage_type        map_ff;
   map_stage_type        map_in;
   logic                 corr_valid_ff;
   logic                 corr_valid_in;
   corr_stage_type       corr_ff;
   corr_stage_type       corr_in;
   logic                 map_pos;
   logic [MagWidth-1:0]  mag;
   logic [ScaleWidth-1:0] g_red;
   logic [ScaleWidth-1:0] g_green;
   logic [ScaleWidth-1:0] g_blue;

   // Rounded correction gain*map >> RoundShift, zero when the map is not positive
   function automatic logic [CorrWidth-1:0] round_corr(input logic [ScaleWidth-1:0] gain,
                                                       input logic [MagWidth-1:0] m,
                                                       input logic pos);
      logic [ProdWidth-1:0] prod;
      logic [ProdWidth-1:0] rounded;
      prod    = ProdWidth'(gain) * ProdWidth'(m);
      rounded = prod + (ProdWidth'(1) << (RoundShift - 1));
      round_corr = pos ? rounded[ProdWidth-1 -: CorrWidth] : '0;
   endfunction

   // Map stage: strength times difference
   assign map_ready = !corr_valid_ff || out_ready;
   assign in_ready  = !map_valid_ff || map_ready;

   always_comb begin
      map_valid_in = in_ready ? in_valid : map_valid_ff;
      map_in       = map_ff;
      if (in_ready && in_valid) begin
         map_in.pix   = in_stage.pix;
         map_in.spill = in_stage.spill;
         map_in.map   = in_stage.factor * in_stage.diff;
      end
   end

   // Gain selection: unit gain on the spill channel when unspill is off
   always_comb begin
      if (cfg.unspill_enable) begin
         g_red   = cfg.gain_red;
         g_green = cfg.gain_green;
         g_blue  = cfg.gain_blue;
      end else begin
         g_red   = (map_ff.spill == ChanRed)   ? QOne : '0;
         g_green = (map_ff.spill == ChanGreen) ? QOne : '0;
         g_blue  = (map_ff.spill == ChanBlue)  ? QOne : '0;
      end
   end

   // Correction stage
   always_comb begin
      map_pos       = (map_ff.map > 0);
      mag           = map_ff.map[MagWidth-1:0];
      corr_valid_in = map_ready ? map_valid_ff : corr_valid_ff;
      corr_in       = corr_ff;
      if (map_ready && map_valid_ff) begin
         corr_in.pix        = map_ff.pix;
         corr_in.spill      = map_ff.spill;
         corr_in.corr_red   = round_corr(g_red, mag, map_pos);
         corr_in.corr_green = round_corr(g_green, mag, map_pos);
         corr_in.corr_blue  = round_corr(g_blue, mag, map_pos);
      end
   end

   // Advance both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff  <= 1'b0;
         corr_valid_ff <= 1'b0;
      end else begin
         map_valid_ff  <= map_valid_in;
         corr_valid_ff <= corr_valid_in;
      end
      map_ff  <= map_in;
      corr_ff <= corr_in;
   end

   assign out_valid = corr_valid_ff;
   assign out_stage = corr_ff;

endmodule

// ----- rtl/csp_apply.sv -----
// Last stage: apply corrections, saturate to Q4.12 and hold the output word.
module csp_apply import csp_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           in_valid,
   output logic           in_ready,
   input  corr_stage_type in_stage,
   output logic           out_valid,
   input  logic           out_ready,
   output pixel_type      out_pix
);

   logic      valid_ff;
   logic      valid_in;
   pixel_type pix_ff;
   pixel_type pix_in;

   // Subtract on the spill channel, add on the others, then clamp
   function automatic logic signed [DataWidth-1:0] apply_sat(
      input logic signed [DataWidth-1:0] c,
      input logic [CorrWidth-1:0]        corr,
      input logic                        is_spill);
      logic signed [SumWidth-1:0] v;
      logic signed [SumWidth-1:0] c_ext;
      logic signed [SumWidth-1:0] corr_ext;
      c_ext    = SumWidth'(c);
      corr_ext = $signed({2'b00, corr});
      v        = is_spill ? (c_ext - corr_ext) : (c_ext + corr_ext);
      if (v > SumWidth'(32767)) begin
         apply_sat = DataWidth'(32767);
      end else if (v < -SumWidth'(32768)) begin
         apply_sat = DataWidth'(-32768);
      end else begin
         apply_sat = v[DataWidth-1:0];
      end
   endfunction

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = in_ready ? in_valid : valid_ff;
      pix_in   = pix_ff;
      if (in_ready && in_valid) begin
         pix_in.red   = apply_sat(in_stage.pix.red, in_stage.corr_red,
                                  in_stage.spill == ChanRed);
         pix_in.green = apply_sat(in_stage.pix.green, in_stage.corr_green,
                                  in_stage.spill == ChanGreen);
         pix_in.blue  = apply_sat(in_stage.pix.blue, in_stage.corr_blue,
                                  in_stage.spill == ChanBlue);
         pix_in.alpha = in_stage.pix.alpha;
      end
   end

   // Hold the result word until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      pix_ff <= pix_in;
   end

   assign out_valid = valid_ff;
   assign out_pix   = pix_ff;

endmodule

// ----- rtl/color_spill_suppress.sv -----
// Top level of the color spill suppression pipeline with its register file.
// Throughput: one word per cycle; each accepted request word passes through four
// register stages (difference, map product, rounded corrections, saturation) on its
// way to the response word; each stalls only when the stage after it is full.
// Reset clears all stage valid bits and loads register defaults:
// spill channel green, simple method, limit red, limit scale 1.0, unspill off, gains 0.
module color_spill_suppress import csp_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   csp_req_if.sink                   req,
   csp_rsp_if.source                 rsp,
   input  logic                      csr_write_enable,
   input  logic [CfgIndexWidth-1:0]  csr_index,
   input  logic [CfgDataWidth-1:0]   csr_write_data
);

   cfg_type        cfg_ff;
   cfg_type        cfg_in;
   pixel_type      req_pix;
   pixel_type      rsp_pix;
   logic           diff_valid;
   logic           corr_ready;
   diff_stage_type diff_stage;
   logic           corr_valid;
   logic           apply_ready;
   corr_stage_type corr_stage;

   // Register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (cfg_index_type'(csr_index))
            CfgSpillChannel:  cfg_in.spill_channel  = csr_write_data[ChanWidth-1:0];
            CfgSpillMethod:   cfg_in.spill_method   = csr_write_data[0];
            CfgLimitChannel:  cfg_in.limit_channel  = csr_write_data[ChanWidth-1:0];
            CfgLimitScale:    cfg_in.limit_scale    = csr_write_data[ScaleWidth-1:0];
            CfgUnspillEnable: cfg_in.unspill_enable = csr_write_data[0];
            CfgGainRed:       cfg_in.gain_red       = csr_write_data[ScaleWidth-1:0];
            CfgGainGreen:     cfg_in.gain_green     = csr_write_data[ScaleWidth-1:0];
            CfgGainBlue:      cfg_in.gain_blue      = csr_write_data[ScaleWidth-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.spill_channel  <= ChanGreen;
         cfg_ff.spill_method   <= MethodSimple;
         cfg_ff.limit_channel  <= ChanRed;
         cfg_ff.limit_scale    <= LimitScaleReset;
         cfg_ff.unspill_enable <= 1'b0;
         cfg_ff.gain_red       <= '0;
         cfg_ff.gain_green     <= '0;
         cfg_ff.gain_blue      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Gather the request word
   always_comb begin
      req_pix.red   = req.in_red;
      req_pix.green = req.in_green;
      req_pix.blue  = req.in_blue;
      req_pix.alpha = req.in_alpha;
   end

   csp_diff u_diff (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .in_valid    (req.valid),
      .in_ready    (req.ready),
      .in_pix      (req_pix),
      .in_strength (req.strength),
      .out_valid   (diff_valid),
      .out_ready   (corr_ready),
      .out_stage   (diff_stage)
   );

   csp_corr u_corr (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (diff_valid),
      .in_ready  (corr_ready),
      .in_stage  (diff_stage),
      .out_valid (corr_valid),
      .out_ready (apply_ready),
      .out_stage (corr_stage)
   );

   csp_apply u_apply (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (corr_valid),
      .in_ready  (apply_ready),
      .in_stage  (corr_stage),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_pix   (rsp_pix)
   );

   // Drive the response word
   assign rsp.out_red   = rsp_pix.red;
   assign rsp.out_green = rsp_pix.green;
   assign rsp.out_blue  = rsp_pix.blue;
   assign rsp.out_alpha = rsp_pix.alpha;

   // An accepted word always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> diff_valid)
      else $error("accepted word missing from difference stage");

   // A stalled difference stage keeps its word
   a_diff_hold: assert property (@(posedge clock) disable iff (reset)
      diff_valid && !corr_ready |=> diff_valid && $stable(diff_stage))
      else $error("difference stage dropped or changed a stalled word");

   // A stalled correction stage keeps its word
   a_corr_hold: assert property (@(posedge clock) disable iff (reset)
      corr_valid && !apply_ready |=> corr_valid && $stable(corr_stage))
      else $error("correction stage dropped or changed a stalled word");

endmodule
